>>> design/bcse_pkg.sv
// Shared types and constants for the battery charge state estimator.
`default_nettype none

package bcse_pkg;

  // Field widths fixed by the register map and the result word
  localparam int unsigned DIV_W      = 10;
  localparam int unsigned INTV_W     = 24;
  localparam int unsigned WIN_W      = 28;
  localparam int unsigned MV8_W      = 8;
  localparam int unsigned DROP_W     = 10;
  localparam int unsigned BATT_W     = 16;
  localparam int unsigned COMP_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SUPPLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_DROP     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DROP   = 3'd7;

  // Register reset values
  localparam logic [DIV_W-1:0]  RST_DIVIDER  = 10'd296;
  localparam logic [INTV_W-1:0] RST_INTERVAL = 24'd1000000;
  localparam logic [WIN_W-1:0]  RST_WINDOW   = 28'd30000000;
  localparam logic [MV8_W-1:0]  RST_STEP_THR = 8'd30;
  localparam logic [MV8_W-1:0]  RST_MARGIN   = 8'd5;
  localparam logic [DROP_W-1:0] RST_CC_DROP  = 10'd150;
  localparam logic [DROP_W-1:0] RST_HOLD     = 10'd96;

  // Battery voltage thresholds in mV
  localparam logic [BATT_W-1:0] KNEE_MV  = 16'd4150;
  localparam logic [BATT_W-1:0] FULL_MV  = 16'd4200;
  localparam logic [BATT_W-1:0] VALID_LO = 16'd2500;
  localparam logic [BATT_W-1:0] VALID_HI = 16'd4500;

  // Taper offset b - knee lies in 1..49
  localparam int unsigned TAPER_W = 6;

  // Moving average weight 1/8
  localparam int unsigned EMA_SHIFT = 3;

  // Taper product width, and the reciprocals for the divide by 100 and by 50:
  // q = (x * RCP) >> RCP_SHIFT, exact for every x below 2^30
  localparam int unsigned DMAG_W    = 16;
  localparam int unsigned RCP_W     = 28;
  localparam int unsigned RCP_SHIFT = 33;
  localparam logic [RCP_W-1:0] SCALE_RCP = 28'd85899346;
  localparam logic [RCP_W-1:0] SPAN_RCP  = 28'd171798692;

  typedef struct packed {
    logic start;
    logic by_span;
  } div_ctl_t;

endpackage

`default_nettype wire

>>> design/bcse_cdiv.sv
// Divider by the constants 100 or 50 through a reciprocal multiply, quotient registered in the cycle after start.
`default_nettype none

module bcse_cdiv #(
  parameter int unsigned N = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bcse_pkg::div_ctl_t ctl,
  input  logic [N-1:0]       dividend,
  output logic               done,
  output logic [N-1:0]       quotient
);

  import bcse_pkg::*;

  localparam int unsigned PW = N + RCP_W;

  logic             done_r, done_nxt;
  logic [N-1:0]     quo_r, quo_nxt;
  logic [RCP_W-1:0] recip;
  logic [PW-1:0]    prod;

  always_comb begin
    // multiply by the rounded-up reciprocal and keep the top bits
    recip    = ctl.by_span ? SPAN_RCP : SCALE_RCP;
    prod     = PW'(dividend) * PW'(recip);
    done_nxt = ctl.start;
    quo_nxt  = ctl.start ? N'(prod >> RCP_SHIFT) : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> design/battery_charge_state_estimator.sv
// Battery charge state estimator: one poll word in, one status word out.
// Each word passes the sequencer steps gate, update, scale multiply, divide by 100, drop rule,
// result load, with the charge taper adding a product and a divide by 50 on the shared
// reciprocal divider. Input is taken only in the idle state, after the previous result load,
// and is taken while a result waits.
// Reset (rst_n, synchronous): registers to their defaults, all estimator state cleared.
`default_nettype none

module battery_charge_state_estimator #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned PIN_BITS  = 12,
  localparam int unsigned IN_W  = ((TIME_BITS + PIN_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 + bcse_pkg::BATT_W + bcse_pkg::COMP_W
                                    + TIME_BITS + PIN_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // poll input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_W-1:0]                    in_tdata,  // now_us, pin_mv, status_level
  input  logic [0:0]                         in_tuser,  // sample_ok
  // status output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // on_external, charging, supply_present, battery_mv, compensated_mv,
  // sample_time_us, smoothed_pin_mv
  output logic [OUT_W-1:0]                   out_tdata,
  output logic [0:0]                         out_tuser, // level_valid
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcse_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import bcse_pkg::*;

  localparam int unsigned PROD_W = PIN_BITS + DIV_W;
  localparam int unsigned SW     = PIN_BITS + 2;
  localparam logic signed [SW-1:0] EMA_ROUND = SW'((1 << EMA_SHIFT) - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_GATE   = 10'b00_0000_0010,
    S_UPD    = 10'b00_0000_0100,
    S_MULB   = 10'b00_0000_1000,
    S_BSTART = 10'b00_0001_0000,
    S_BWAIT  = 10'b00_0010_0000,
    S_DROP   = 10'b00_0100_0000,
    S_DSTART = 10'b00_1000_0000,
    S_DWAIT  = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DIV_W-1:0]  div_r;
  logic [INTV_W-1:0] intv_r;
  logic [WIN_W-1:0]  win_r;
  logic [MV8_W-1:0]  thr_r;
  logic [MV8_W-1:0]  mar_r;
  logic [DROP_W-1:0] cc_r;
  logic [DROP_W-1:0] hold_r;

  // captured poll word
  logic [TIME_BITS-1:0] now_r;
  logic                 ok_r;
  logic [PIN_BITS-1:0]  mv_r;
  logic                 stat_r;

  // estimator state
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [TIME_BITS-1:0] trt_r, trt_nxt;
  logic [PIN_BITS-1:0]  ema_r, ema_nxt;
  logic [PIN_BITS-1:0]  prev_r, prev_nxt;
  logic [PIN_BITS-1:0]  ref_r, ref_nxt;
  logic                 chg_r, chg_nxt;
  logic                 conf_r, conf_nxt;
  logic                 sup_r, sup_nxt;
  logic                 take_r, take_nxt;
  logic                 due_r, due_nxt;

  // datapath working registers
  logic [PROD_W-1:0] prod_r;
  logic [BATT_W-1:0] b_r;
  logic [DROP_W-1:0] drop_r, drop_nxt;

  // result word
  logic                 ov_r, ov_nxt;
  logic                 o_sup_r;
  logic                 o_chg_r;
  logic [BATT_W-1:0]    o_b_r;
  logic [COMP_W-1:0]    o_comp_r;
  logic                 o_lvl_r;
  logic [TIME_BITS-1:0] o_time_r;
  logic [PIN_BITS-1:0]  o_ema_r;

  // sampling gate
  logic [TIME_BITS:0] lst_diff;
  logic [TIME_BITS:0] trt_diff;
  logic               gate_take;
  logic               gate_due;

  // flag and average update
  logic signed [SW-1:0] mv_s, prev_s, ema_s, ref_s, thr_s, mar_s;
  logic signed [SW-1:0] step_s, ediff, edsum, equo, ema_sum, ref_hi, ref_lo;
  logic [PIN_BITS-1:0]  ema_new;
  logic                 upd_chg, upd_conf, upd_sup, upd_trend;

  // shared multiplier
  logic [PIN_BITS-1:0] mul_a;
  logic [DIV_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;

  // drop rule
  logic [BATT_W-1:0]  taper_off;
  logic               span_neg;
  logic [DROP_W-1:0]  span_mag;
  logic               taper_on;
  logic [DROP_W+1:0]  drop_sum;
  logic [COMP_W:0]    comp_full;
  logic               out_load;

  // shared divider
  div_ctl_t          div_ctl;
  logic [PROD_W-1:0] div_in;
  logic              div_done;
  logic [PROD_W-1:0] div_q;

  bcse_cdiv #(
    .N (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // A backwards time step counts as not yet elapsed: the borrow bit blocks it.
  always_comb begin
    lst_diff  = {1'b0, now_r} - {1'b0, last_r};
    trt_diff  = {1'b0, now_r} - {1'b0, trt_r};
    gate_take = ok_r && ((last_r == '0) ||
                (!lst_diff[TIME_BITS] &&
                 (lst_diff[TIME_BITS-1:0] >= TIME_BITS'(intv_r))));
    gate_due  = !trt_diff[TIME_BITS] &&
                (trt_diff[TIME_BITS-1:0] >= TIME_BITS'(win_r));
  end

  // Charge, supply and trend decisions, in the order the estimator applies them.
  always_comb begin
    mv_s   = signed'({2'b00, mv_r});
    prev_s = signed'({2'b00, prev_r});
    ema_s  = signed'({2'b00, ema_r});
    ref_s  = signed'({2'b00, ref_r});
    thr_s  = signed'(SW'(thr_r));
    mar_s  = signed'(SW'(mar_r));
    step_s = mv_s - prev_s;
    ref_hi = ref_s + mar_s;
    ref_lo = ref_s - mar_s;

    // 1/8 of the error, rounded toward zero
    ediff   = mv_s - ema_s;
    edsum   = ediff + EMA_ROUND;
    equo    = ediff[SW-1] ? (edsum >>> EMA_SHIFT) : (ediff >>> EMA_SHIFT);
    ema_sum = ema_s + equo;
    ema_new = (ema_r == '0) ? mv_r : ema_sum[PIN_BITS-1:0];

    upd_chg  = chg_r;
    upd_conf = conf_r;
    upd_sup  = sup_r;

    // status low latches the line as confirmed
    if (!stat_r) begin
      upd_conf = 1'b1;
      upd_chg  = 1'b1;
      upd_sup  = 1'b1;
    end else if (upd_conf) begin
      upd_chg = 1'b0;
    end

    // raw step: plug or unplug, off while no previous reading
    if (prev_r != '0) begin
      if (step_s > thr_s) begin
        upd_sup = 1'b1;
        if (!upd_conf) begin
          upd_chg = 1'b1;
        end
      end else if (step_s < -thr_s) begin
        upd_sup = 1'b0;
        upd_chg = 1'b0;
      end
    end

    // long-window trend while the status line is unconfirmed
    upd_trend = !upd_conf && due_r;
    if (upd_trend && (ref_r != '0)) begin
      if (ema_s > ref_hi) begin
        upd_chg = 1'b1;
      end else if (ema_s < ref_lo) begin
        upd_chg = 1'b0;
      end
    end
  end

  // Drop rule helpers
  always_comb begin
    taper_off = b_r - KNEE_MV;
    span_neg  = (cc_r < hold_r);
    span_mag  = span_neg ? (hold_r - cc_r) : (cc_r - hold_r);
    taper_on  = sup_r && chg_r && (b_r > KNEE_MV) && (b_r < FULL_MV);
    drop_sum  = span_neg ? ({2'b00, cc_r} + {1'b0, div_q[DROP_W:0]})
                         : ({2'b00, cc_r} - {1'b0, div_q[DROP_W:0]});
    comp_full = {2'b00, b_r} - {{(COMP_W + 1 - DROP_W){1'b0}}, drop_r};
  end

  // Shared multiplier: divider scaling first, taper product second
  always_comb begin
    if (state_r == S_DROP) begin
      mul_a = PIN_BITS'(taper_off[TAPER_W-1:0]);
      mul_b = span_mag;
    end else begin
      mul_a = ema_r;
      mul_b = div_r;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    div_ctl.start   = (state_r == S_BSTART) || (state_r == S_DSTART);
    div_ctl.by_span = (state_r == S_DSTART);
    div_in          = (state_r == S_DSTART) ? PROD_W'(prod_r[DMAG_W-1:0]) : prod_r;
  end

  assign out_load = (state_r == S_OUT) && (!ov_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    trt_nxt   = trt_r;
    ema_nxt   = ema_r;
    prev_nxt  = prev_r;
    ref_nxt   = ref_r;
    chg_nxt   = chg_r;
    conf_nxt  = conf_r;
    sup_nxt   = sup_r;
    take_nxt  = take_r;
    due_nxt   = due_r;
    drop_nxt  = drop_r;
    ov_nxt    = ov_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_GATE;
        end
      end
      S_GATE: begin
        take_nxt  = gate_take;
        due_nxt   = gate_due;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // a failed or early tick leaves all state as it is
        if (take_r) begin
          chg_nxt  = upd_chg;
          conf_nxt = upd_conf;
          sup_nxt  = upd_sup;
          prev_nxt = mv_r;
          ema_nxt  = ema_new;
          last_nxt = now_r;
          if (upd_trend) begin
            ref_nxt = ema_r;
            trt_nxt = now_r;
          end
        end
        state_nxt = S_MULB;
      end
      S_MULB: begin
        state_nxt = S_BSTART;
      end
      S_BSTART: begin
        state_nxt = S_BWAIT;
      end
      S_BWAIT: begin
        if (div_done) begin
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (taper_on) begin
          state_nxt = S_DSTART;
        end else begin
          if (!sup_r) begin
            drop_nxt = '0;
          end else if (!chg_r) begin
            drop_nxt = hold_r;
          end else if (b_r <= KNEE_MV) begin
            drop_nxt = cc_r;
          end else begin
            drop_nxt = hold_r;
          end
          state_nxt = S_OUT;
        end
      end
      S_DSTART: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          drop_nxt  = drop_sum[DROP_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (out_load) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // writing the start-up supply estimate loads the supply flag
    if (cfg_valid && (cfg_index == CFG_INIT_SUPPLY)) begin
      sup_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= '0;
      trt_r   <= '0;
      ema_r   <= '0;
      prev_r  <= '0;
      ref_r   <= '0;
      chg_r   <= 1'b0;
      conf_r  <= 1'b0;
      sup_r   <= 1'b0;
      take_r  <= 1'b0;
      due_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      trt_r   <= trt_nxt;
      ema_r   <= ema_nxt;
      prev_r  <= prev_nxt;
      ref_r   <= ref_nxt;
      chg_r   <= chg_nxt;
      conf_r  <= conf_nxt;
      sup_r   <= sup_nxt;
      take_r  <= take_nxt;
      due_r   <= due_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= RST_DIVIDER;
      intv_r <= RST_INTERVAL;
      win_r  <= RST_WINDOW;
      thr_r  <= RST_STEP_THR;
      mar_r  <= RST_MARGIN;
      cc_r   <= RST_CC_DROP;
      hold_r <= RST_HOLD;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIVIDER:   div_r  <= cfg_data[DIV_W-1:0];
        CFG_INTERVAL:  intv_r <= cfg_data[INTV_W-1:0];
        CFG_WINDOW:    win_r  <= cfg_data[WIN_W-1:0];
        CFG_STEP_THR:  thr_r  <= cfg_data[MV8_W-1:0];
        CFG_MARGIN:    mar_r  <= cfg_data[MV8_W-1:0];
        CFG_CC_DROP:   cc_r   <= cfg_data[DROP_W-1:0];
        CFG_HOLD_DROP: hold_r <= cfg_data[DROP_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r  <= in_tdata[TIME_BITS-1:0];
      mv_r   <= in_tdata[TIME_BITS +: PIN_BITS];
      stat_r <= in_tdata[TIME_BITS + PIN_BITS];
      ok_r   <= in_tuser[0];
    end
    if ((state_r == S_MULB) || (state_r == S_DROP)) begin
      prod_r <= mul_p;
    end
    if ((state_r == S_BWAIT) && div_done) begin
      b_r <= div_q[BATT_W-1:0];
    end
    drop_r <= drop_nxt;
    if (out_load) begin
      o_sup_r  <= sup_r;
      o_chg_r  <= chg_r;
      o_b_r    <= b_r;
      o_comp_r <= comp_full[COMP_W-1:0];
      o_lvl_r  <= (b_r > VALID_LO) && (b_r < VALID_HI);
      o_time_r <= last_r;
      o_ema_r  <= ema_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'({o_ema_r, o_time_r, o_comp_r, o_b_r, o_sup_r, o_chg_r, o_sup_r});
  assign out_tuser  = o_lvl_r;

endmodule

`default_nettype wire
